@@ src/utf8d_pkg.sv @@
// shared types and constants for the permissive utf-8 decoder
// no dependencies; imported by the front, back and top level

package utf8d_pkg;

  // byte classes worked out by the front end
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4
  } cls_t;

  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one queued input word
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    cls_t       cls;
  } qent_t;

  // one byte as held in the back end
  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
  } bent_t;

  // back end status seen by the top level
  typedef struct packed {
    logic       busy;
    logic [1:0] held_cnt;
  } back_st_t;

  // bytes a sequence needs, counting its lead
  function automatic logic [2:0] seq_len(input cls_t cls);
    logic [2:0] n;
    case (cls)
      CLS_LEAD2: n = 3'd2;
      CLS_LEAD3: n = 3'd3;
      CLS_LEAD4: n = 3'd4;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

@@ src/utf8d_front.sv @@
// front end: takes input words, classifies each byte and queues it
// depends on utf8d_pkg

module utf8d_front
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_text,
  output logic       q_valid,
  input  logic       q_pop,
  output qent_t      q_head
);

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    if (b[7] == 1'b0)          c = CLS_ASCII;
    else if (b[6] == 1'b0)     c = CLS_CONT;
    else if (b[5] == 1'b0)     c = CLS_LEAD2;
    else if (b[4] == 1'b0)     c = CLS_LEAD3;
    else                       c = CLS_LEAD4;
    return c;
  endfunction

  qent_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               push;

  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data: in_data_byte, eot: in_end_of_text,
                           cls: classify(in_data_byte)};
    end
  end

endmodule

@@ src/utf8d_back.sv @@
// back end: walks held bytes plus the new byte, one result per cycle while out_stall is low
// depends on utf8d_pkg

module utf8d_back
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  qent_t       q_head,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_point,
  output logic        out_replaced,
  output logic        out_run_last,
  output logic        out_text_done,
  output back_st_t    st
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t      state_r, state_nxt;
  bent_t       buf_r [4];
  bent_t       buf_nxt [4];
  bent_t       held_r [3];
  bent_t       held_nxt [3];
  logic [1:0]  held_cnt_r, held_cnt_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        fin_r, fin_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [20:0] out_cp_r, out_cp_nxt;
  logic        out_rep_r, out_rep_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_done_r, out_done_nxt;

  assign q_pop          = (state_r == ST_IDLE) && q_valid;
  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;
  assign out_replaced   = out_rep_r;
  assign out_run_last   = out_last_r;
  assign out_text_done  = out_done_r;
  assign st             = '{busy: (state_r == ST_WALK), held_cnt: held_cnt_r};

  always_comb begin
    logic [1:0]  ix;
    bent_t       e0, e1, e2, e3, en;
    logic [2:0]  avail, n, adv, nidx, navail;
    logic        c1, c2, c3, emit, hold, cut, last, step, out_free;
    logic [20:0] rcp;
    logic        rrep;

    state_nxt     = state_r;
    buf_nxt       = buf_r;
    held_nxt      = held_r;
    held_cnt_nxt  = held_cnt_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    fin_nxt       = fin_r;
    out_cp_nxt    = out_cp_r;
    out_rep_nxt   = out_rep_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    out_free      = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;

    ix    = idx_r[1:0];
    e0    = buf_r[ix];
    e1    = buf_r[ix + 2'd1];
    e2    = buf_r[ix + 2'd2];
    e3    = buf_r[ix + 2'd3];
    avail = len_r - idx_r;
    n     = seq_len(e0.cls);
    c1    = (e1.data[7:6] == 2'b10);
    c2    = (e2.data[7:6] == 2'b10);
    c3    = (e3.data[7:6] == 2'b10);

    emit = 1'b0;
    hold = 1'b0;
    cut  = 1'b0;
    adv  = 3'd1;
    rcp  = REPL_CP;
    rrep = 1'b1;

    unique case (e0.cls) inside
      CLS_ASCII: begin
        emit = 1'b1;
        rcp  = {13'd0, e0.data};
        rrep = 1'b0;
      end
      CLS_CONT: begin
        emit = 1'b1;
      end
      CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
        if (n > avail) begin
          // sequence not complete yet
          if (fin_r) begin
            emit = 1'b1;
            cut  = 1'b1;
          end else begin
            hold = 1'b1;
          end
        end else if (!c1) begin
          emit = 1'b1;
          adv  = 3'd1;
        end else if (n >= 3'd3 && !c2) begin
          emit = 1'b1;
          adv  = 3'd2;
        end else if (n == 3'd4 && !c3) begin
          emit = 1'b1;
          adv  = 3'd3;
        end else begin
          emit = 1'b1;
          adv  = n;
          rrep = 1'b0;
          case (e0.cls)
            CLS_LEAD2: rcp = {10'd0, e0.data[4:0], e1.data[5:0]};
            CLS_LEAD3: rcp = {5'd0, e0.data[3:0], e1.data[5:0], e2.data[5:0]};
            default:   rcp = {e0.data[2:0], e1.data[5:0], e2.data[5:0], e3.data[5:0]};
          endcase
        end
      end
      default: begin
        emit = 1'b1;
      end
    endcase

    // would the byte after this result only be held
    nidx   = idx_r + adv;
    en     = buf_r[nidx[1:0]];
    navail = len_r - nidx;
    last   = cut || (nidx == len_r) || (!fin_r && (seq_len(en.cls) > navail));

    step = (state_r == ST_WALK) && (hold || out_free);

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          for (int j = 0; j < 4; j++) begin
            if (2'(j) < held_cnt_r && j < 3) begin
              buf_nxt[j] = held_r[2'(j)];
            end else begin
              buf_nxt[j] = '{data: q_head.data, cls: q_head.cls};
            end
          end
          len_nxt      = {1'b0, held_cnt_r} + 3'd1;
          idx_nxt      = 3'd0;
          fin_nxt      = q_head.eot;
          held_cnt_nxt = 2'd0;
          state_nxt    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (step) begin
          if (hold) begin
            for (int r = 0; r < 3; r++) begin
              held_nxt[r] = buf_r[ix + 2'(r)];
            end
            held_cnt_nxt = avail[1:0];
            state_nxt    = ST_IDLE;
          end else if (emit) begin
            out_valid_nxt = 1'b1;
            out_cp_nxt    = rcp;
            out_rep_nxt   = rrep;
            out_last_nxt  = last;
            out_done_nxt  = last && fin_r;
            idx_nxt       = nidx;
            if (cut || nidx == len_r) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_cnt_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_cnt_r  <= held_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    buf_r      <= buf_nxt;
    held_r     <= held_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    fin_r      <= fin_nxt;
    out_cp_r   <= out_cp_nxt;
    out_rep_r  <= out_rep_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

endmodule

@@ src/permissive_utf8_decoder.sv @@
// top level of the permissive utf-8 to code point decoder
// depends on utf8d_pkg, utf8d_front and utf8d_back

// Takes one byte of UTF-8 text per input word, with a flag on the final byte
// of the string, and gives decoded code points. ASCII passes through, stray
// continuation bytes, broken sequences and sequences cut off by the end of
// the string come out as U+FFFD with the replaced flag set; there is no
// overlong or surrogate check, and 0xF8-0xFF count as four-byte leads. A
// byte may give no result (it is held until its sequence completes) or up
// to four. run_last marks the final result a byte causes, text_done the
// final result of the string. The back end takes a byte from the queue
// only while idle, so it is through with one byte before it takes the
// next; it then walks the held bytes plus the new one, making one result a
// cycle while out_stall is low, and goes back to idle when the bytes are
// used up or the rest are left held. A two-word queue between front
// and back keeps input words flowing while a result waits on out_stall.

module permissive_utf8_decoder
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_point,
  output logic        out_replaced,
  output logic        out_run_last,
  output logic        out_text_done
);

  // queue head between the two halves
  logic     q_valid;
  logic     q_pop;
  qent_t    q_head;
  back_st_t back_st;

  // classify and queue incoming words
  utf8d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_end_of_text (in_end_of_text),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_head         (q_head)
  );

  // walk held bytes plus the new one, emit results
  utf8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_head         (q_head),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_replaced   (out_replaced),
    .out_run_last   (out_run_last),
    .out_text_done  (out_text_done),
    .st             (back_st)
  );

  // a word leaves the queue only when there is one and the walker is free
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && !back_st.busy))
    else $error("queue popped while empty or while walking");

  // every substitution carries the replacement character
  a_repl_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_replaced) |-> (out_code_point == REPL_CP))
    else $error("replacement result without U+FFFD");

  // held bytes only sit between words, never while the walker is busy
  a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (back_st.held_cnt != 2'd0) |-> !back_st.busy)
    else $error("bytes held while walking");

  // text_done only ever on the final result of a word
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_done) |-> out_run_last)
    else $error("text_done on a result that is not the last of its word");

endmodule

@@ tb/utf8_cp_checker.sv @@
// watches both channels of the utf-8 decoder and checks every result word
// keeps its own decoder state; depends on utf8d_pkg for the byte classes

module utf8_cp_checker
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_text,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [20:0] out_code_point,
  input  logic        out_replaced,
  input  logic        out_run_last,
  input  logic        out_text_done,
  output int unsigned mismatches,
  output int unsigned cps_waiting
);

  localparam logic [7:0] CONT_MIN  = 8'h80;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;

  typedef struct packed {
    logic [20:0] code_point;
    logic        replaced;
    logic        run_last;
    logic        text_done;
  } cp_word_t;

  cp_word_t    want_q [$];
  logic [7:0]  held [3];
  int unsigned held_n = 0;
  int unsigned bad = 0;

  function automatic cls_t byte_class(input logic [7:0] b);
    if (b < CONT_MIN) return CLS_ASCII;
    if (b < LEAD2_MIN) return CLS_CONT;
    if (b >= LEAD4_MIN) return CLS_LEAD4;
    if (b >= LEAD3_MIN) return CLS_LEAD3;
    return CLS_LEAD2;
  endfunction

  function automatic cp_word_t cp_of(input logic [20:0] cp, input logic rep);
    cp_word_t w;
    w.code_point = cp;
    w.replaced   = rep;
    w.run_last   = 1'b0;
    w.text_done  = 1'b0;
    return w;
  endfunction

  // appends one expected word at the tail
  function automatic void queue_cp(input cp_word_t w);
    want_q.insert(want_q.size(), w);
  endfunction

  // decodes one accepted byte against the held bytes, queueing its code points
  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    logic [7:0]  run [4];
    logic [20:0] cp;
    logic        broken;
    cp_word_t    w;
    int unsigned len, i, k, h, need, first;
    len   = 0;
    i     = 0;
    first = want_q.size();
    for (h = 0; h < held_n; h++) begin
      run[len] = held[h];
      len++;
    end
    run[len] = b;
    len++;
    held_n = 0;
    while (i < len) begin
      case (byte_class(run[i]))
        CLS_ASCII: begin
          queue_cp(cp_of({13'd0, run[i]}, 1'b0));
          i++;
        end
        CLS_CONT: begin
          queue_cp(cp_of(REPL_CP, 1'b1));
          i++;
        end
        default: begin
          case (byte_class(run[i]))
            CLS_LEAD4: begin
              need = 4;
              cp   = {18'd0, run[i][2:0]};
            end
            CLS_LEAD3: begin
              need = 3;
              cp   = {17'd0, run[i][3:0]};
            end
            default: begin
              need = 2;
              cp   = {16'd0, run[i][4:0]};
            end
          endcase
          if (i + need > len) begin
            if (eot) begin
              // cut off by the end: one replacement, the rest is dropped
              queue_cp(cp_of(REPL_CP, 1'b1));
              i = len;
            end else begin
              while (i < len) begin
                held[held_n] = run[i];
                held_n++;
                i++;
              end
            end
          end else begin
            broken = 1'b0;
            k      = 1;
            while (k < need && !broken) begin
              if (run[i + k][7:6] != 2'b10) begin
                broken = 1'b1;
              end else begin
                cp = {cp[14:0], run[i + k][5:0]};
                k++;
              end
            end
            if (broken) begin
              // the breaking byte gets another go as a lead
              queue_cp(cp_of(REPL_CP, 1'b1));
              i += k;
            end else begin
              queue_cp(cp_of(cp, 1'b0));
              i += need;
            end
          end
        end
      endcase
    end
    if (want_q.size() > first) begin
      w = want_q.pop_back();
      w.run_last  = 1'b1;
      w.text_done = eot;
      queue_cp(w);
    end
    if (eot) held_n = 0;
  endfunction

  function automatic void check_field(input string name, input logic [20:0] want,
                                      input logic [20:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      bad++;
    end
  endfunction

  always @(posedge clk) begin : watch
    cp_word_t exp_w;
    if (!rst_n) begin
      held_n = 0;
      want_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_end_of_text);
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $display("%0t: code point expected none got %0h", $time, out_code_point);
          bad++;
        end else begin
          exp_w = want_q.pop_front();
          check_field("code_point", exp_w.code_point, out_code_point);
          check_field("replaced", {20'd0, exp_w.replaced}, {20'd0, out_replaced});
          check_field("run_last", {20'd0, exp_w.run_last}, {20'd0, out_run_last});
          check_field("text_done", {20'd0, exp_w.text_done}, {20'd0, out_text_done});
        end
      end
    end
    mismatches  <= bad;
    cps_waiting <= want_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// top of the utf-8 decoder testbench: clock, reset, byte stimulus and verdict
// depends on permissive_utf8_decoder and utf8_cp_checker

module tb_top;

  localparam int unsigned WORD_COUNT  = 310;
  // cycles with no word moving on either channel before the run is called hung
  localparam int unsigned STUCK_LIMIT = 2000;

  // directed text, end-of-text flag in bit 8
  localparam logic [8:0] DIRECTED [23] = '{
    9'h000,                          // lowest byte
    9'h17F,                          // highest ascii, ends a string
    9'h080, 9'h0BF,                  // lone continuation bytes at both ends
    9'h0C2, 9'h0A9,                  // two-byte sequence
    9'h0E2, 9'h082, 9'h0AC,          // three-byte sequence
    9'h0F0, 9'h09F, 9'h098, 9'h080,  // four-byte sequence
    9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF,  // 0xff lead, largest code point
    9'h0E2, 9'h041,                  // broken sequence, the 'A' is decoded again
    9'h0F0, 9'h09F, 9'h141,          // cut off by the end, odd last byte dropped
    9'h1C3                           // lone lead as the last byte of a string
  };

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte   = 8'h00;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [20:0] out_code_point;
  logic        out_replaced;
  logic        out_run_last;
  logic        out_text_done;

  int unsigned mismatches;
  int unsigned cps_waiting;
  int unsigned words_sent = 0;
  int unsigned stall_left = 0;
  int unsigned stuck      = 0;
  // while set, neither side idles, so the block runs flat out
  bit          calm       = 1'b0;

  permissive_utf8_decoder i_dut (.*);

  utf8_cp_checker u_cp_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned idle_gap();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // random lead byte for an n-byte sequence; four-byte leads span 0xf0-0xff
  function automatic logic [7:0] lead_of(input int unsigned n);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (n)
      2:       r[7:5] = 3'b110;
      3:       r[7:4] = 4'b1110;
      default: r[7:4] = 4'b1111;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    r[7:6] = 2'b10;
    return r;
  endfunction

  // offers one word after a random gap and holds it until it is taken
  task automatic send_word(input logic [7:0] b, input logic eot);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // holds the input back until every predicted code point has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cps_waiting != 0) @(posedge clk);
  endtask

  // one random chunk of text: mostly well-formed sequences, some noise,
  // broken sequences and strings that end part way through a sequence
  task automatic send_chunk();
    logic [7:0]  run_q [$];
    logic [7:0]  b;
    logic        eot;
    int unsigned kind, need, k;
    kind = $urandom_range(0, 19);
    need = $urandom_range(2, 4);
    eot  = ($urandom_range(0, 7) == 0);
    if (kind < 4) begin
      b = 8'($urandom_range(0, 127));
      run_q.insert(run_q.size(), b);
    end else if (kind < 13) begin
      run_q.insert(run_q.size(), lead_of(need));
      for (k = 1; k < need; k++) run_q.insert(run_q.size(), cont_byte());
    end else if (kind < 16) begin
      b = 8'($urandom_range(0, 255));
      run_q.insert(run_q.size(), b);
    end else if (kind < 18) begin
      // lead, some continuations, then a byte that is not one
      run_q.insert(run_q.size(), lead_of(need));
      for (k = $urandom_range(1, need - 1); k > 1; k--) begin
        run_q.insert(run_q.size(), cont_byte());
      end
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      run_q.insert(run_q.size(), b);
    end else begin
      // string ends before the sequence is complete
      run_q.insert(run_q.size(), lead_of(need));
      for (k = $urandom_range(0, need - 2); k > 0; k--) begin
        run_q.insert(run_q.size(), cont_byte());
      end
      eot = 1'b1;
    end
    foreach (run_q[j]) send_word(run_q[j], eot && (j == run_q.size() - 1));
  endtask

  // result side: after each taken word, and now and then while idle,
  // hold stall for a random number of cycles
  always @(posedge clk) begin : sink
    int unsigned n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      n = idle_gap();
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      n = ($urandom_range(0, 5) == 0) ? idle_gap() : 0;
      stall_left <= n;
      out_stall  <= (n != 0);
    end
  end

  // hang detection: counts cycles in which no word moves at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("permissive_utf8_decoder verification failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin : stimulus
    bit mid_drained;
    mid_drained = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[j]) send_word(DIRECTED[j][7:0], DIRECTED[j][8]);
    drain();
    while (words_sent < WORD_COUNT) begin
      // switch between idling and back-to-back stretches now and then
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      send_chunk();
      if (!mid_drained && words_sent >= WORD_COUNT / 2) begin
        mid_drained = 1'b1;
        drain();
      end
    end
    drain();
    // a little extra time so any stray result word is seen
    repeat (20) @(posedge clk);
    if (mismatches == 0 && cps_waiting == 0) begin
      $display("permissive_utf8_decoder verification clean");
    end else begin
      $display("permissive_utf8_decoder verification failed");
    end
    $finish;
  end

endmodule
